/* rtl/core/sbrb_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbrb_pkg: shared types and codes of the seekable byte ring buffer
// Command, origin and status codes, the operation queue entry and the
// state type of the back end.
// ----------------------------------------------------------------------------
package sbrb_pkg;

	// widest ring index carried in a queue entry (ring of up to 65536 slots)
	localparam int SLOT_W = 16;
	// longest read that returns bytes
	localparam int MAX_READ_RUN = 64;
	// operation queue depth between front and back
	localparam int QDEPTH = 4;

	typedef enum logic [2:0] {
		CMD_WRITE = 3'd0,
		CMD_ZERO  = 3'd1,
		CMD_READ  = 3'd2,
		CMD_CLEAN = 3'd3,
		CMD_SEEK  = 3'd4
	} cmd_t;

	typedef enum logic [1:0] {
		ORG_START   = 2'd0,
		ORG_CURRENT = 2'd1,
		ORG_END     = 2'd2
	} origin_t;

	typedef enum logic [1:0] {
		ST_OK         = 2'd0,
		ST_NO_DATA    = 2'd1,
		ST_NO_SPACE   = 2'd2,
		ST_BAD_OFFSET = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		OP_NOTE  = 2'd0,
		OP_WRITE = 2'd1,
		OP_ZERO  = 2'd2,
		OP_READ  = 2'd3
	} op_kind_t;

	typedef enum logic {
		BK_IDLE = 1'b0,
		BK_RUN  = 1'b1
	} back_state_t;

	typedef struct packed {
		op_kind_t          kind;
		logic [SLOT_W-1:0] addr;
		logic [6:0]        n;
		logic [7:0]        wbyte;
		status_t           status;
		logic [9:0]        used;
		logic [9:0]        pos;
	} entry_t;

	typedef struct packed {
		logic   valid;
		entry_t entry;
	} head_t;

endpackage

/* rtl/core/sbrb_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbrb_front: command front end
// Accepts commands, checks them against the ring bookkeeping, updates the
// indices and counts at once and queues the memory work for the back end.
// ----------------------------------------------------------------------------
module sbrb_front import sbrb_pkg::*; #(
	parameter int RING_SLOTS = 1024,
	localparam int PW = $clog2(RING_SLOTS)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               accept,
	input  logic [2:0]         command,
	input  logic [7:0]         write_byte,
	input  logic [6:0]         count,
	input  logic               discard,
	input  logic               cleanup,
	input  logic signed [10:0] seek_offset,
	input  logic [1:0]         seek_origin,
	input  logic               cfg_we,
	input  logic [9:0]         capacity,
	output logic               push,
	output entry_t             entry,
	output logic [PW-1:0]      cap
);

	localparam int XW   = PW + 1;
	localparam int CMPW = ((PW > 7) ? PW : 7) + 1;
	localparam int SW   = ((PW > 11) ? PW : 11) + 2;
	localparam int CFW  = (PW > 10) ? PW : 10;
	localparam int CAP_RST = (1023 > RING_SLOTS - 1) ? RING_SLOTS - 1 : 1023;

	logic [PW-1:0] cap_q, oldest_q, append_q, held_q, rp_q;
	logic [PW-1:0] oldest_d, append_d, held_d, rp_d;
	logic [XW-1:0] slots;
	logic [CMPW-1:0] free_w, fresh_w, cnt_w;
	logic [PW-1:0] cnt_p, rp_sum;
	logic signed [SW-1:0] off_s, base_s, target_s, held_s;
	logic origin_bad;
	logic seek_bad;
	logic [CFW-1:0] cfg_ext;
	logic [PW-1:0] cap_new;

	function automatic logic [PW-1:0] wrap_add(input logic [PW-1:0] a,
		input logic [PW-1:0] b, input logic [XW-1:0] s);
		logic [XW-1:0] t;
		t = XW'(a) + XW'(b);
		if (t >= s) begin
			t = t - s;
		end
		return t[PW-1:0];
	endfunction

	always_comb begin
		slots   = XW'(cap_q) + XW'(1);
		free_w  = CMPW'(cap_q - held_q);
		fresh_w = CMPW'(held_q - rp_q);
		cnt_w   = CMPW'(count);
		cnt_p   = cnt_w[PW-1:0];
		rp_sum  = rp_q + cnt_p;
		off_s   = SW'(seek_offset);
		held_s  = signed'(SW'(held_q));
		origin_bad = 1'b0;
		case (origin_t'(seek_origin))
			ORG_START:   base_s = '0;
			ORG_CURRENT: base_s = signed'(SW'(rp_q));
			ORG_END:     base_s = held_s;
			default: begin
				base_s     = '0;
				origin_bad = 1'b1;
			end
		endcase
		target_s = base_s + off_s;
		seek_bad = origin_bad || (target_s < 0) || (target_s > held_s);
	end

	always_comb begin
		oldest_d     = oldest_q;
		append_d     = append_q;
		held_d       = held_q;
		rp_d         = rp_q;
		entry.kind   = OP_NOTE;
		entry.addr   = '0;
		entry.n      = 7'd1;
		entry.wbyte  = write_byte;
		entry.status = ST_OK;
		case (cmd_t'(command))
			CMD_WRITE: begin
				if (free_w == '0) begin
					entry.status = ST_NO_SPACE;
				end else begin
					entry.kind = OP_WRITE;
					entry.addr = SLOT_W'(append_q);
					append_d   = wrap_add(append_q, PW'(1), slots);
					held_d     = held_q + PW'(1);
				end
			end
			CMD_ZERO: begin
				if (count != 7'd0) begin
					if (free_w < cnt_w) begin
						entry.status = ST_NO_SPACE;
					end else begin
						entry.kind = OP_ZERO;
						entry.n    = count;
						entry.addr = SLOT_W'(append_q);
						append_d   = wrap_add(append_q, cnt_p, slots);
						held_d     = held_q + cnt_p;
					end
				end
			end
			CMD_READ: begin
				if (count != 7'd0) begin
					if ((fresh_w < cnt_w) || (!discard && (count > 7'(MAX_READ_RUN)))) begin
						entry.status = ST_NO_DATA;
					end else begin
						if (!discard) begin
							entry.kind = OP_READ;
							entry.n    = count;
							entry.addr = SLOT_W'(wrap_add(oldest_q, rp_q, slots));
						end
						if (cleanup) begin
							oldest_d = wrap_add(oldest_q, rp_sum, slots);
							held_d   = held_q - rp_sum;
							rp_d     = '0;
						end else begin
							rp_d = rp_sum;
						end
					end
				end
			end
			CMD_CLEAN: begin
				oldest_d = wrap_add(oldest_q, rp_q, slots);
				held_d   = held_q - rp_q;
				rp_d     = '0;
			end
			CMD_SEEK: begin
				if (seek_bad) begin
					entry.status = ST_BAD_OFFSET;
				end else begin
					rp_d = target_s[PW-1:0];
				end
			end
			default: begin
			end
		endcase
		entry.used = 10'(held_d);
		entry.pos  = 10'(rp_d);
	end

	// zero selects the largest capacity, too large saturates
	always_comb begin
		cfg_ext = CFW'(capacity);
		if ((cfg_ext == '0) || (cfg_ext > CFW'(RING_SLOTS - 1))) begin
			cap_new = PW'(RING_SLOTS - 1);
		end else begin
			cap_new = cfg_ext[PW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q    <= PW'(CAP_RST);
			oldest_q <= '0;
			append_q <= '0;
			held_q   <= '0;
			rp_q     <= '0;
		end else if (cfg_we) begin
			cap_q    <= cap_new;
			oldest_q <= '0;
			append_q <= '0;
			held_q   <= '0;
			rp_q     <= '0;
		end else if (accept) begin
			oldest_q <= oldest_d;
			append_q <= append_d;
			held_q   <= held_d;
			rp_q     <= rp_d;
		end
	end

	assign push = accept && !cfg_we;
	assign cap  = cap_q;

`ifndef SYNTH
	a_pos_in_held: assert property (@(posedge clk) disable iff (!arst_n)
		rp_q <= held_q)
		else $error("read position beyond held bytes");
	a_held_in_cap: assert property (@(posedge clk) disable iff (!arst_n)
		held_q <= cap_q)
		else $error("held bytes exceed capacity");
	a_cfg_empties: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> (held_q == '0) && (rp_q == '0) && (append_q == '0))
		else $error("capacity write did not empty the ring");
`endif

endmodule

/* rtl/core/sbrb_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbrb_queue: operation queue
// Short register queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module sbrb_queue import sbrb_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  entry_t wr_entry,
	input  logic   pop,
	output head_t  head,
	output logic   full,
	output logic   empty
);

	localparam int QW = $clog2(QDEPTH);

	entry_t        slot_q [QDEPTH];
	logic [QW-1:0] wr_q, rd_q;
	logic [QW:0]   count_q;

	assign full       = (count_q == (QW+1)'(QDEPTH));
	assign empty      = (count_q == '0);
	assign head.valid = !empty;
	assign head.entry = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= wr_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == QW'(QDEPTH - 1)) ? '0 : wr_q + QW'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == QW'(QDEPTH - 1)) ? '0 : rd_q + QW'(1);
			end
			count_q <= count_q + (QW+1)'(push) - (QW+1)'(pop);
		end
	end

`ifndef SYNTH
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push || pop)
		else $error("push into full queue");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		empty |-> !pop)
		else $error("pop from empty queue");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (QW+1)'(QDEPTH))
		else $error("queue count out of range");
`endif

endmodule

/* rtl/core/sbrb_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbrb_back: memory back end
// Runs queued operations against the byte memory one byte per cycle and
// drives the registered result strobe.
// ----------------------------------------------------------------------------
module sbrb_back import sbrb_pkg::*; #(
	parameter int RING_SLOTS = 1024,
	localparam int PW = $clog2(RING_SLOTS)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  head_t         head,
	input  logic [PW-1:0] cap,
	output logic          pop,
	output logic          idle,
	output logic          result_valid,
	output logic [1:0]    status,
	output logic [7:0]    read_byte,
	output logic          byte_valid,
	output logic          last,
	output logic [9:0]    used_count,
	output logic [9:0]    seek_position
);

	back_state_t   st_q, st_d;
	entry_t        cur_q;
	logic [PW-1:0] addr_q;
	logic [6:0]    left_q;
	logic          run, fin, mem_we, mem_re, emit;
	logic [7:0]    wdata;

	logic [7:0] mem [RING_SLOTS];
	logic [7:0] rdata_s1;
	logic       res_valid_s1, byte_valid_s1, last_s1;
	status_t    status_s1;
	logic [9:0] used_s1, pos_s1;

	always_comb begin
		case (st_q)
			BK_IDLE: st_d = head.valid ? BK_RUN : BK_IDLE;
			BK_RUN:  st_d = (fin && !head.valid) ? BK_IDLE : BK_RUN;
			default: st_d = BK_IDLE;
		endcase
	end

	always_comb begin
		run    = (st_q == BK_RUN);
		fin    = run && (left_q == 7'd1);
		pop    = head.valid && (!run || fin);
		mem_we = run && ((cur_q.kind == OP_WRITE) || (cur_q.kind == OP_ZERO));
		mem_re = run && (cur_q.kind == OP_READ);
		emit   = run && ((cur_q.kind == OP_READ) || (left_q == 7'd1));
		wdata  = (cur_q.kind == OP_WRITE) ? cur_q.wbyte : 8'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= BK_IDLE;
			left_q <= '0;
		end else begin
			st_q <= st_d;
			if (pop) begin
				left_q <= head.entry.n;
			end else if (run) begin
				left_q <= left_q - 7'd1;
			end
		end
	end

	// advance the ring address, wrap after the last slot in use
	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q  <= head.entry;
			addr_q <= head.entry.addr[PW-1:0];
		end else if (run) begin
			addr_q <= (addr_q == cap) ? '0 : addr_q + PW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[addr_q] <= wdata;
		end
		if (mem_re) begin
			rdata_s1 <= mem[addr_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_s1 <= 1'b0;
		end else begin
			res_valid_s1 <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			byte_valid_s1 <= mem_re;
			last_s1       <= (left_q == 7'd1);
			status_s1     <= cur_q.status;
			used_s1       <= cur_q.used;
			pos_s1        <= cur_q.pos;
		end
	end

	assign idle          = (st_q == BK_IDLE) && !res_valid_s1;
	assign result_valid  = res_valid_s1;
	assign status        = status_s1;
	assign read_byte     = byte_valid_s1 ? rdata_s1 : 8'd0;
	assign byte_valid    = byte_valid_s1;
	assign last          = last_s1;
	assign used_count    = used_s1;
	assign seek_position = pos_s1;

`ifndef SYNTH
	a_run_continues: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_s1 && !last_s1 |=> res_valid_s1)
		else $error("gap inside a read run");
	a_run_has_bytes: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_s1 && !last_s1 |-> byte_valid_s1)
		else $error("non-final result without a byte");
	a_byte_from_read: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_s1 && byte_valid_s1 |-> $past(mem_re))
		else $error("byte result without a memory read");
`endif

endmodule

/* rtl/core/seekable_byte_ring_buffer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// seekable_byte_ring_buffer: byte ring buffer with read seek
// Holds up to capacity bytes; bytes already read stay until cleaned.
//
// Usage:
// - Command channel: a transaction is taken at a clock edge with start high
//   and busy low. busy is high while the four-entry operation queue is full
//   and in the cycle in which a capacity write is taken.
// - Result channel: result_valid marks each result for one cycle; the
//   receiver cannot stall it. last marks the final result of a command.
// - Configuration: capacity is written when cfg_valid and cfg_ready are both
//   high; cfg_ready is high only while no work is outstanding. A write empties
//   the ring.
// - Flow: an accepted command is registered in the operation queue, taken by
//   the back end, and its result is registered before it reaches the ports.
//   A write byte or a non-data command yields one result, a zero run of n
//   bytes writes its bytes and yields one result at its end, and a read of n
//   bytes yields one result per byte per cycle.
// - Sustained rate: one command per cycle for single-byte work while busy is
//   low, set by the one port of the byte memory in the back end.
// - Reset: indices and counts clear, capacity returns to its largest legal
//   value up to 1023; memory contents are not cleared.
// ----------------------------------------------------------------------------
module seekable_byte_ring_buffer import sbrb_pkg::*; #(
	parameter int RING_SLOTS = 1024
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [2:0]         command,
	input  logic [7:0]         write_byte,
	input  logic [6:0]         count,
	input  logic               discard,
	input  logic               cleanup,
	input  logic signed [10:0] seek_offset,
	input  logic [1:0]         seek_origin,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [9:0]         capacity,
	output logic               result_valid,
	output logic [1:0]         status,
	output logic [7:0]         read_byte,
	output logic               byte_valid,
	output logic               last,
	output logic [9:0]         used_count,
	output logic [9:0]         seek_position
);

	localparam int PW = $clog2(RING_SLOTS);

	logic          accept, cfg_we, push, pop, q_full, q_empty, back_idle;
	entry_t        new_entry;
	head_t         head;
	logic [PW-1:0] cap;

	// hold commands off while a capacity write empties the ring
	assign busy      = q_full || cfg_we;
	assign accept    = start && !busy;
	assign cfg_ready = q_empty && back_idle;
	assign cfg_we    = cfg_valid && cfg_ready;

	sbrb_front #(.RING_SLOTS(RING_SLOTS)) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.command     (command),
		.write_byte  (write_byte),
		.count       (count),
		.discard     (discard),
		.cleanup     (cleanup),
		.seek_offset (seek_offset),
		.seek_origin (seek_origin),
		.cfg_we      (cfg_we),
		.capacity    (capacity),
		.push        (push),
		.entry       (new_entry),
		.cap         (cap)
	);

	sbrb_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr_entry (new_entry),
		.pop      (pop),
		.head     (head),
		.full     (q_full),
		.empty    (q_empty)
	);

	sbrb_back #(.RING_SLOTS(RING_SLOTS)) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head          (head),
		.cap           (cap),
		.pop           (pop),
		.idle          (back_idle),
		.result_valid  (result_valid),
		.status        (status),
		.read_byte     (read_byte),
		.byte_valid    (byte_valid),
		.last          (last),
		.used_count    (used_count),
		.seek_position (seek_position)
	);

endmodule

/* verif/sbrb_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbrb_checker: result predictor and scoreboard for the seekable ring buffer
// Watches the command, configuration and result channels, keeps its own copy
// of the ring state, predicts each result of every accepted command and
// compares it field by field with what the block returns.
// ----------------------------------------------------------------------------
module sbrb_checker import sbrb_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               busy,
	input  logic [2:0]         command,
	input  logic [7:0]         write_byte,
	input  logic [6:0]         count,
	input  logic               discard,
	input  logic               cleanup,
	input  logic signed [10:0] seek_offset,
	input  logic [1:0]         seek_origin,
	input  logic               cfg_valid,
	input  logic               cfg_ready,
	input  logic [9:0]         capacity,
	input  logic               result_valid,
	input  logic [1:0]         status,
	input  logic [7:0]         read_byte,
	input  logic               byte_valid,
	input  logic               last,
	input  logic [9:0]         used_count,
	input  logic [9:0]         seek_position,
	output int                 mismatches,
	output int                 outstanding
);

	localparam int RING_SLOTS = 1024;
	localparam int unsigned MAX_CAPACITY = RING_SLOTS - 1;

	typedef struct packed {
		status_t    st;
		logic [7:0] data;
		logic       data_valid;
		logic       final_flag;
		logic [9:0] used;
		logic [9:0] pos;
	} ring_result_t;

	logic [7:0]   ring_mem [RING_SLOTS];
	int unsigned  ring_cap;
	int unsigned  oldest_slot;
	int unsigned  append_slot;
	int unsigned  held_cnt;
	int unsigned  read_pos;
	ring_result_t expected_results [$];
	int           err_count;

	task automatic push_result(input status_t st, input logic [7:0] data, input logic dv,
		input logic fl);
		ring_result_t r;
		r.st         = st;
		r.data       = data;
		r.data_valid = dv;
		r.final_flag = fl;
		r.used       = held_cnt[9:0];
		r.pos        = read_pos[9:0];
		expected_results.push_back(r);
	endtask

	// drop the bytes already read and rewind the position
	task automatic release_read();
		if (read_pos != 0) begin
			oldest_slot = (oldest_slot + read_pos) % (ring_cap + 1);
			held_cnt    = held_cnt - read_pos;
			read_pos    = 0;
		end
	endtask

	task automatic predict_command(input logic [2:0] cmd, input logic [7:0] wbyte,
		input logic [6:0] cnt, input logic dsc, input logic cln,
		input logic signed [10:0] offset, input logic [1:0] origin);
		int unsigned slots;
		int unsigned free_bytes;
		int unsigned fresh;
		int unsigned rd_start;
		int unsigned n_bytes;
		int          target;
		status_t     st;
		logic [7:0]  run_bytes [MAX_READ_RUN];
		slots      = ring_cap + 1;
		free_bytes = ring_cap - held_cnt;
		st         = ST_OK;
		case (cmd)
			CMD_WRITE: begin
				if (free_bytes < 1) begin
					st = ST_NO_SPACE;
				end else begin
					ring_mem[append_slot] = wbyte;
					append_slot = (append_slot + 1) % slots;
					held_cnt++;
				end
			end
			CMD_ZERO: begin
				if (cnt != 0) begin
					if (free_bytes < cnt) begin
						st = ST_NO_SPACE;
					end else begin
						for (int i = 0; i < cnt; i++) begin
							ring_mem[append_slot] = 8'h00;
							append_slot = (append_slot + 1) % slots;
						end
						held_cnt += cnt;
					end
				end
			end
			CMD_READ: begin
				if (cnt != 0) begin
					fresh = held_cnt - read_pos;
					if (fresh < cnt || (!dsc && cnt > MAX_READ_RUN)) begin
						st = ST_NO_DATA;
					end else begin
						rd_start = (oldest_slot + read_pos) % slots;
						n_bytes  = dsc ? 0 : cnt;
						for (int i = 0; i < n_bytes; i++)
							run_bytes[i] = ring_mem[(rd_start + i) % slots];
						read_pos += cnt;
						if (cln)
							release_read();
						// a returning read reports one result per byte and nothing else
						if (n_bytes != 0) begin
							for (int i = 0; i < n_bytes; i++)
								push_result(ST_OK, run_bytes[i], 1'b1, i == n_bytes - 1);
							return;
						end
					end
				end
			end
			CMD_CLEAN: begin
				release_read();
			end
			CMD_SEEK: begin
				case (origin)
					ORG_START:   target = offset;
					ORG_CURRENT: target = int'(read_pos) + offset;
					ORG_END:     target = int'(held_cnt) + offset;
					default:     target = -1;
				endcase
				if (target < 0 || target > int'(held_cnt))
					st = ST_BAD_OFFSET;
				else
					read_pos = target;
			end
			default: ;
		endcase
		push_result(st, 8'h00, 1'b0, 1'b1);
	endtask

	task automatic check_field(input string name, input logic [9:0] expv,
		input logic [9:0] actv);
		if (actv !== expv) begin
			$error("%s mismatch: expected %0d, actual %0d", name, expv, actv);
			err_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		ring_result_t want;
		if (!arst_n) begin
			ring_cap    = MAX_CAPACITY;
			oldest_slot = 0;
			append_slot = 0;
			held_cnt    = 0;
			read_pos    = 0;
			err_count   = 0;
			expected_results.delete();
			mismatches  <= 0;
			outstanding <= 0;
		end else begin
			if (result_valid) begin
				if (expected_results.size() == 0) begin
					$error("result with no transaction pending: status %0d, used %0d",
						status, used_count);
					err_count++;
				end else begin
					want = expected_results.pop_front();
					check_field("status", want.st, status);
					check_field("read_byte", want.data, read_byte);
					check_field("byte_valid", want.data_valid, byte_valid);
					check_field("last", want.final_flag, last);
					check_field("used_count", want.used, used_count);
					check_field("seek_position", want.pos, seek_position);
				end
			end
			// a capacity write empties the ring; zero selects the largest size
			if (cfg_valid && cfg_ready) begin
				ring_cap    = (capacity == '0) ? MAX_CAPACITY : capacity;
				oldest_slot = 0;
				append_slot = 0;
				held_cnt    = 0;
				read_pos    = 0;
			end
			if (start && !busy)
				predict_command(command, write_byte, count, discard, cleanup, seek_offset,
					seek_origin);
			mismatches  <= err_count;
			outstanding <= expected_results.size();
		end
	end

endmodule

/* verif/seekable_byte_ring_buffer_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// seekable_byte_ring_buffer_tb: command-level test of the seekable ring buffer
// Runs a directed sequence on a small ring, then random command streams over
// several capacities and sender idle rates. Results are checked by
// sbrb_checker; this module drives stimulus and reports the verdict.
// ----------------------------------------------------------------------------
module seekable_byte_ring_buffer_tb;
	import sbrb_pkg::*;

	localparam int LIMIT_CYCLES    = 400000;
	localparam int ITEMS_PER_PHASE = 41;
	localparam int N_PHASES        = 6;

	localparam logic [2:0] CMD_RSVD_FIRST = 3'd5;
	localparam logic [2:0] CMD_RSVD_LAST  = 3'd7;
	localparam logic [1:0] ORG_INVALID    = 2'd3;

	typedef struct {
		logic [2:0]         cmd;
		logic [7:0]         wbyte;
		logic [6:0]         cnt;
		logic               dsc;
		logic               cln;
		logic signed [10:0] offset;
		logic [1:0]         origin;
	} cmd_item_t;

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic [2:0]         command;
	logic [7:0]         write_byte;
	logic [6:0]         count;
	logic               discard;
	logic               cleanup;
	logic signed [10:0] seek_offset;
	logic [1:0]         seek_origin;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [9:0]         capacity;
	logic               result_valid;
	logic [1:0]         status;
	logic [7:0]         read_byte;
	logic               byte_valid;
	logic               last;
	logic [9:0]         used_count;
	logic [9:0]         seek_position;
	int                 mismatches;
	int                 outstanding;
	int                 cycle_count = 0;
	int                 idle_pct;
	logic [9:0]         cap_plan [N_PHASES];
	int                 idle_plan [N_PHASES];
	cmd_item_t          directed_items [$];

	seekable_byte_ring_buffer u_top (.*);

	sbrb_checker u_checker (.*);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == LIMIT_CYCLES) begin
			$display("FAILURE");
			$finish;
		end
	end

	function automatic cmd_item_t cmd_item(input logic [2:0] cmd, input logic [7:0] wbyte,
		input logic [6:0] cnt, input logic dsc, input logic cln,
		input logic signed [10:0] offset, input logic [1:0] origin);
		cmd_item_t it;
		it.cmd    = cmd;
		it.wbyte  = wbyte;
		it.cnt    = cnt;
		it.dsc    = dsc;
		it.cln    = cln;
		it.offset = offset;
		it.origin = origin;
		return it;
	endfunction

	// mostly short runs and near seeks so reads land on held data
	function automatic cmd_item_t rand_item();
		cmd_item_t it;
		int        pick;
		it.wbyte  = 8'($urandom);
		it.cnt    = ($urandom_range(7) == 0) ? 7'($urandom_range(127)) :
			7'($urandom_range(1, 8));
		it.dsc    = ($urandom_range(3) == 0);
		it.cln    = ($urandom_range(3) == 0);
		it.offset = ($urandom_range(7) == 0) ? 11'($urandom) : 11'($urandom_range(16)) - 11'd8;
		it.origin = ($urandom_range(15) == 0) ? ORG_INVALID : 2'($urandom_range(2));
		pick = $urandom_range(99);
		if (pick < 32)
			it.cmd = CMD_WRITE;
		else if (pick < 44)
			it.cmd = CMD_ZERO;
		else if (pick < 74)
			it.cmd = CMD_READ;
		else if (pick < 82)
			it.cmd = CMD_CLEAN;
		else if (pick < 97)
			it.cmd = CMD_SEEK;
		else
			it.cmd = 3'($urandom_range(CMD_RSVD_FIRST, CMD_RSVD_LAST));
		return it;
	endfunction

	task automatic issue_command(input cmd_item_t it);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start       <= 1'b1;
		command     <= it.cmd;
		write_byte  <= it.wbyte;
		count       <= it.cnt;
		discard     <= it.dsc;
		cleanup     <= it.cln;
		seek_offset <= it.offset;
		seek_origin <= it.origin;
		do @(posedge clk); while (busy);
	endtask

	// write capacity only once every pending result has come back
	task automatic write_capacity(input logic [9:0] value);
		start <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		cfg_valid <= 1'b1;
		capacity  <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		arst_n      <= 1'b0;
		start       <= 1'b0;
		command     <= CMD_WRITE;
		write_byte  <= '0;
		count       <= '0;
		discard     <= 1'b0;
		cleanup     <= 1'b0;
		seek_offset <= '0;
		seek_origin <= ORG_START;
		cfg_valid   <= 1'b0;
		capacity    <= '0;
		idle_pct    = 0;
		cap_plan    = '{10'd8, 10'd1023, 10'd1, 10'd0, 10'd600, 10'd45};
		idle_plan   = '{0, 59, 27, 0, 59, 27};

		// directed sequence, run on a ring of 8 bytes
		directed_items.push_back(cmd_item(CMD_READ, 8'h00, 7'd0, 1'b0, 1'b0, 11'sd0, ORG_START));
		directed_items.push_back(cmd_item(CMD_ZERO, 8'h00, 7'd0, 1'b0, 1'b0, 11'sd0, ORG_START));
		directed_items.push_back(cmd_item(CMD_READ, 8'h00, 7'd1, 1'b0, 1'b0, 11'sd0, ORG_START));
		directed_items.push_back(cmd_item(CMD_WRITE, 8'h00, 7'd0, 1'b0, 1'b0, 11'sd0, ORG_START));
		directed_items.push_back(cmd_item(CMD_WRITE, 8'hFF, 7'd0, 1'b0, 1'b0, 11'sd0, ORG_START));
		directed_items.push_back(cmd_item(CMD_ZERO, 8'h00, 7'd6, 1'b0, 1'b0, 11'sd0, ORG_START));
		directed_items.push_back(cmd_item(CMD_WRITE, 8'hA5, 7'd0, 1'b0, 1'b0, 11'sd0, ORG_START));
		directed_items.push_back(cmd_item(CMD_ZERO, 8'h00, 7'd127, 1'b0, 1'b0, 11'sd0, ORG_START));
		directed_items.push_back(cmd_item(CMD_READ, 8'h00, 7'd2, 1'b0, 1'b0, 11'sd0, ORG_START));
		directed_items.push_back(cmd_item(CMD_SEEK, 8'h00, 7'd0, 1'b0, 1'b0, 11'sd0, ORG_START));
		directed_items.push_back(cmd_item(CMD_READ, 8'h00, 7'd3, 1'b1, 1'b0, 11'sd0, ORG_START));
		directed_items.push_back(cmd_item(CMD_SEEK, 8'h00, 7'd0, 1'b0, 1'b0, -11'sd1, ORG_CURRENT));
		// most negative offset from the end
		directed_items.push_back(cmd_item(CMD_SEEK, 8'h00, 7'd0, 1'b0, 1'b0, 11'h400, ORG_END));
		directed_items.push_back(cmd_item(CMD_SEEK, 8'h00, 7'd0, 1'b0, 1'b0, 11'sd1023, ORG_START));
		directed_items.push_back(cmd_item(CMD_SEEK, 8'h00, 7'd0, 1'b0, 1'b0, 11'sd0, ORG_INVALID));
		directed_items.push_back(cmd_item(CMD_SEEK, 8'h00, 7'd0, 1'b0, 1'b0, 11'sd0, ORG_END));
		directed_items.push_back(cmd_item(CMD_READ, 8'h00, 7'd1, 1'b0, 1'b0, 11'sd0, ORG_START));
		directed_items.push_back(cmd_item(CMD_SEEK, 8'h00, 7'd0, 1'b0, 1'b0, 11'sd0, ORG_START));
		directed_items.push_back(cmd_item(CMD_READ, 8'h00, 7'd100, 1'b0, 1'b0, 11'sd0, ORG_START));
		directed_items.push_back(cmd_item(CMD_READ, 8'h00, 7'd8, 1'b0, 1'b1, 11'sd0, ORG_START));
		directed_items.push_back(cmd_item(CMD_CLEAN, 8'h00, 7'd0, 1'b0, 1'b0, 11'sd0, ORG_START));
		directed_items.push_back(cmd_item(CMD_RSVD_FIRST, 8'h00, 7'd0, 1'b0, 1'b0, 11'sd0,
			ORG_START));
		directed_items.push_back(cmd_item(CMD_RSVD_LAST, 8'h00, 7'd0, 1'b0, 1'b0, 11'sd0,
			ORG_START));
		directed_items.push_back(cmd_item(CMD_WRITE, 8'h5A, 7'd0, 1'b0, 1'b0, 11'sd0, ORG_START));
		directed_items.push_back(cmd_item(CMD_READ, 8'h00, 7'd1, 1'b1, 1'b1, 11'sd0, ORG_START));

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		for (int p = 0; p < N_PHASES; p++) begin
			write_capacity(cap_plan[p]);
			idle_pct = idle_plan[p];
			if (p == 0)
				foreach (directed_items[i])
					issue_command(directed_items[i]);
			repeat (ITEMS_PER_PHASE) issue_command(rand_item());
		end

		start <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (16) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
